// ===== sv/ttcw_pkg.sv =====
// Shared constants and types for the text terminal character writer.
package ttcw_pkg;

   // Default grid bounds
   localparam int MAX_ROWS_DEFAULT = 32;
   localparam int MAX_COLS_DEFAULT = 128;

   // Stream and configuration port widths
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Configuration register widths and reset values
   localparam int ROWS_REG_W = 6;
   localparam int COLS_REG_W = 8;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd24;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   // Control characters and the printable range
   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;

   // Request kinds carried in tuser
   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

endpackage

// ===== sv/ttcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ttcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_terminal_char_writer.sv =====
// Text terminal character writer: screen cell store, cursor and dirty row marks.
//
// Usage
//   Requests arrive on the req_ stream, one transaction per item; tuser holds
//   the kind (put character, read cell, clear dirty marks). Every request
//   yields exactly one transaction on the rsp_ stream carrying the cursor,
//   the bell flag and, for a read, the cell byte and its row dirty mark.
//   The csr_ port writes rows_in_use (index 0) and cols_in_use (index 1);
//   write it only while no request is in flight.
// Sequence
//   A put, read or clear passes from idle to the completion state, which loads
//   the response register once it frees; the next request is taken after that.
//   A line feed without scroll clears the new cursor row, one cell per cycle.
//   A scrolling line feed copies each cell up one row (none when R, the
//   effective row count, is 2), then clears the last text row; the screen RAM
//   moves one cell per cycle through its one read and one write port.
// Reset and stalls
//   After reset the screen RAM is swept to zero, one cell per cycle, over all
//   MAX_ROWS * 2**ceil(log2(MAX_COLS)) cells (4096 at the defaults); no
//   request is taken meanwhile. A stalled response waits in its register
//   and the block holds the finished item until the slot frees.
module text_terminal_char_writer #(
   parameter int MAX_ROWS = ttcw_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = ttcw_pkg::MAX_COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad[23:20]
   input  logic [ttcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: kind[1:0]
   input  logic [ttcw_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: cursor_row[4:0], cursor_col[11:5], bell[12], cell_char[20:13],
   //        row_dirty[21], zero pad[23:22]
   output logic [ttcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration write port
   input  logic                              csr_we,
   input  logic [ttcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ttcw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import ttcw_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_COPY,
      ST_DRAIN,
      ST_ZERO,
      ST_DONE
   } state_type;

   // Control state
   state_type            state_ff,     state_in;
   logic [ADDR_W-1:0]    sweep_ff,     sweep_in;
   logic [ROW_W-1:0]     row_ff,       row_in;
   logic [COL_W-1:0]     col_ff,       col_in;
   logic                 wr_pend_ff,   wr_pend_in;
   logic [ADDR_W-1:0]    wr_addr_ff,   wr_addr_in;
   logic [ROW_W-1:0]     cur_row_ff,   cur_row_in;
   logic [COL_W-1:0]     cur_col_ff,   cur_col_in;
   logic [MAX_ROWS-1:0]  dirty_ff,     dirty_in;
   logic [ROWS_REG_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [COLS_REG_W-1:0] cols_cfg_ff, cols_cfg_in;

   // Finished item waiting for the response register
   logic                 p_bell_ff,    p_bell_in;
   logic                 p_read_ff,    p_read_in;
   logic                 p_ok_ff,      p_ok_in;
   logic                 p_dirty_ff,   p_dirty_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [4:0]           rsp_row_ff,   rsp_row_in;
   logic [6:0]           rsp_col_ff,   rsp_col_in;
   logic                 rsp_bell_ff,  rsp_bell_in;
   logic [7:0]           rsp_char_ff,  rsp_char_in;
   logic                 rsp_dirty_ff, rsp_dirty_in;

   // Screen RAM port signals
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [7:0]           ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [7:0]           ram_rdata;

   // Effective geometry
   logic [ROWS_W-1:0]    eff_rows;
   logic [COLS_W-1:0]    eff_cols;
   logic [ROW_W-1:0]     last_row;
   logic [COL_W-1:0]     last_col;

   // Request fields
   kind_type             req_kind;
   logic [7:0]           req_char;
   logic [4:0]           req_row;
   logic [6:0]           req_col;

   assign req_kind = kind_type'(req_tuser);
   assign req_char = req_tdata[7:0];
   assign req_row  = req_tdata[12:8];
   assign req_col  = req_tdata[19:13];

   // Clamp the configured geometry to the grid
   always_comb begin
      if (32'(rows_cfg_ff) < 32'd2) begin
         eff_rows = ROWS_W'(2);
      end else if (32'(rows_cfg_ff) > 32'(MAX_ROWS)) begin
         eff_rows = ROWS_W'(MAX_ROWS);
      end else begin
         eff_rows = ROWS_W'(rows_cfg_ff);
      end
      if (32'(cols_cfg_ff) < 32'd1) begin
         eff_cols = COLS_W'(1);
      end else if (32'(cols_cfg_ff) > 32'(MAX_COLS)) begin
         eff_cols = COLS_W'(MAX_COLS);
      end else begin
         eff_cols = COLS_W'(cols_cfg_ff);
      end
   end

   assign last_row = ROW_W'(eff_rows - ROWS_W'(2));
   assign last_col = COL_W'(eff_cols - COLS_W'(1));

   // Next-state logic
   always_comb begin
      logic [ROW_W-1:0]    lim_row;
      logic [COL_W-1:0]    lim_col;
      logic [ROW_W-1:0]    new_row;
      logic [COL_W-1:0]    new_col;
      logic [MAX_ROWS-1:0] scroll_mask;
      logic                read_ok;

      state_in     = state_ff;
      sweep_in     = sweep_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      dirty_in     = dirty_ff;
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      p_bell_in    = p_bell_ff;
      p_read_in    = p_read_ff;
      p_ok_in      = p_ok_ff;
      p_dirty_in   = p_dirty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_bell_in  = rsp_bell_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_dirty_in = rsp_dirty_ff;

      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      lim_row     = (cur_row_ff > last_row) ? last_row : cur_row_ff;
      lim_col     = (cur_col_ff > last_col) ? last_col : cur_col_ff;
      new_row     = lim_row;
      new_col     = lim_col;
      scroll_mask = '0;
      read_ok     = (32'(req_row) < 32'(MAX_ROWS)) && (32'(req_col) < 32'(MAX_COLS));

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_cfg_in = csr_wdata[ROWS_REG_W-1:0];
            CSR_COLS_IN_USE: cols_cfg_in = csr_wdata[COLS_REG_W-1:0];
            default: ;
         endcase
      end

      // Drop the response once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Zero the whole screen RAM after reset
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            if (32'(sweep_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         // Accept a request and do its single-cycle part
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in   = ST_DONE;
               p_bell_in  = 1'b0;
               p_read_in  = 1'b0;
               p_ok_in    = 1'b0;
               p_dirty_in = 1'b0;
               case (req_kind)
                  KIND_PUT: begin
                     if (req_char >= CH_PRINT_LO && req_char <= CH_PRINT_HI) begin
                        ram_we    = 1'b1;
                        ram_waddr = {lim_row, lim_col};
                        ram_wdata = req_char;
                        if (lim_col != last_col) begin
                           new_col = lim_col + COL_W'(1);
                        end
                     end else if (req_char == CH_LF) begin
                        col_in = '0;
                        if (lim_row == last_row) begin
                           // Scroll: rows above the status row all turn dirty
                           for (int i = 0; i < MAX_ROWS; i++) begin
                              scroll_mask[i] = (i <= 32'(last_row));
                           end
                           row_in   = '0;
                           state_in = (last_row == '0) ? ST_ZERO : ST_COPY;
                        end else begin
                           new_row  = lim_row + ROW_W'(1);
                           state_in = ST_ZERO;
                        end
                     end else if (req_char == CH_CR) begin
                        new_col = '0;
                     end
                     p_bell_in  = (req_char == CH_BEL);
                     cur_row_in = new_row;
                     cur_col_in = new_col;
                     dirty_in   = dirty_ff | scroll_mask;
                     dirty_in[new_row] = 1'b1;
                  end
                  KIND_READ: begin
                     ram_re    = 1'b1;
                     ram_raddr = {ROW_W'(req_row), COL_W'(req_col)};
                     p_read_in = 1'b1;
                     p_ok_in   = read_ok;
                     if (read_ok) begin
                        p_dirty_in = dirty_ff[ROW_W'(req_row)];
                     end
                  end
                  KIND_CLEAR: begin
                     dirty_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         // Move each cell up one row; the write of a cell comes in the cycle after its read
         ST_COPY: begin
            ram_re     = 1'b1;
            ram_raddr  = {row_ff + ROW_W'(1), col_ff};
            wr_pend_in = 1'b1;
            wr_addr_in = {row_ff, col_ff};
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (col_ff == last_col) begin
               col_in = '0;
               if (row_ff == last_row - ROW_W'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end

         // Finish the last trailing copy write
         ST_DRAIN: begin
            ram_we     = 1'b1;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            wr_pend_in = 1'b0;
            col_in     = '0;
            state_in   = ST_ZERO;
         end

         // Clear the cursor row, one cell per cycle
         ST_ZERO: begin
            ram_we    = 1'b1;
            ram_waddr = {cur_row_ff, col_ff};
            if (col_ff == last_col) begin
               state_in = ST_DONE;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end

         // Load the response register when it frees
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = 5'(cur_row_ff);
               rsp_col_in   = 7'(cur_col_ff);
               rsp_bell_in  = p_bell_ff;
               rsp_char_in  = (p_read_ff && p_ok_ff) ? ram_rdata : 8'd0;
               rsp_dirty_in = p_dirty_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         dirty_ff     <= '0;
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wr_pend_ff   <= wr_pend_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         dirty_ff     <= dirty_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      wr_addr_ff   <= wr_addr_in;
      p_bell_ff    <= p_bell_in;
      p_read_ff    <= p_read_in;
      p_ok_ff      <= p_ok_in;
      p_dirty_ff   <= p_dirty_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_bell_ff  <= rsp_bell_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   // Screen cell store
   ttcw_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_dirty_ff, rsp_char_ff, rsp_bell_ff,
                        rsp_col_ff, rsp_row_ff};

`ifndef SYNTHESIS
   // An accepted transaction always moves out of the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

   // The cursor row never exceeds MAX_ROWS - 2, the last text row of a full-size grid
   assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) <= MAX_ROWS - 2))
      else $error("cursor row beyond last text row");

   // A trailing copy write never collides with the row clear
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ZERO) |-> !wr_pend_ff)
      else $error("copy write pending during row clear");

   // A response appears only out of the completion state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response loaded outside completion");
`endif

endmodule
